@@ design/wmmas_pkg.sv @@
// Shared types and constants for the windowed min/max/average statistics block.
// Used by the interfaces, the controller, the datapath and the top level.
package wmmas_pkg;

  localparam int PADDR_WIDTH = 5;
  localparam int PDATA_WIDTH = 64;
  localparam int TS_WIDTH    = 63;
  localparam int PORT_WIDTH  = 64;

  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_MODE     = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  localparam logic [1:0] MODE_ALL = 2'd0;
  localparam logic [1:0] MODE_MIN = 2'd1;
  localparam logic [1:0] MODE_MAX = 2'd2;
  localparam logic [1:0] MODE_AVG = 2'd3;

  typedef enum logic [1:0] {
    KIND_CUR = 2'd0,
    KIND_MIN = 2'd1,
    KIND_MAX = 2'd2,
    KIND_AVG = 2'd3
  } kind_t;

  typedef struct packed {
    logic                enable;
    logic [1:0]          mode;
    logic [TS_WIDTH-1:0] interval;
  } cfg_t;

  typedef struct packed {
    logic  take_item;
    logic  update_window;
    logic  close_window;
    logic  load_out;
    kind_t out_kind;
    logic  out_last;
  } cmd_t;

  typedef struct packed {
    logic close_now;
    logic avg_ready;
  } stat_t;

endpackage

@@ design/wmmas_ifs.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on wmmas_pkg for the field widths.
interface wmmas_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [wmmas_pkg::PORT_WIDTH-1:0] operand;
  logic [wmmas_pkg::TS_WIDTH-1:0]      timestamp;

  modport source (output valid, output command, output operand, output timestamp,
                  input ready);
  modport sink   (input valid, input command, input operand, input timestamp,
                  output ready);
endinterface

interface wmmas_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic signed [wmmas_pkg::PORT_WIDTH-1:0] result_value;
  logic                                last;

  modport source (output valid, output kind, output result_value, output last,
                  input ready);
  modport sink   (input valid, input kind, input result_value, input last,
                  output ready);
endinterface

@@ design/windowed_min_max_avg_stats_top.sv @@
// Windowed min/max/average statistics counter, top level.
// Items arrive on in_ch; each returns the updated current value on out_ch, and an
// item whose timestamp passes the deadline while enabled also returns the window's
// min, max and truncated average (or one of them, by aggregate mode), in that order,
// with last set on the final result of the item.
// Configuration goes through the APB port: enable at 0x00, aggregate mode at 0x08,
// interval ticks at 0x10; writes belong in idle periods only.
// The current-value result is valid the cycle after acceptance. With enable low an
// item can be accepted every cycle while the output register is free. With enable
// high each item is first taken and then folded into the window before the next one
// is accepted. A window close that reports the average waits for the restoring
// divider, which starts with the window update, then gives one quotient bit per cycle.
// Results sit in a single output register; when the receiver holds ready low the
// block stalls in place and accepts the next item as soon as that register frees.
// Synchronous reset clears the configuration, the current value, the window and the
// deadline, and empties the output register.
// Depends on wmmas_pkg, the channel interfaces, wmmas_ctrl, wmmas_dp and wmmas_div.
module windowed_min_max_avg_stats_top #(
  parameter int VALUE_WIDTH = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wmmas_pkg::PADDR_WIDTH-1:0]  paddr,
  input  logic [wmmas_pkg::PDATA_WIDTH-1:0]  pwdata,
  output logic [wmmas_pkg::PDATA_WIDTH-1:0]  prdata,
  output logic                               pready,
  wmmas_in_if.sink                           in_ch,
  wmmas_out_if.source                        out_ch
);

  localparam int TW = wmmas_pkg::TS_WIDTH;

  logic             enable;
  logic [1:0]       aggregate_mode;
  logic [TW-1:0]    interval_ticks;
  logic [1:0]       reg_index;
  logic             reg_write;
  wmmas_pkg::cfg_t  cfg;
  wmmas_pkg::cmd_t  cmd;
  wmmas_pkg::stat_t st;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:3];
  assign reg_write = psel && penable && pwrite;

  assign cfg.enable   = enable;
  assign cfg.mode     = aggregate_mode;
  assign cfg.interval = interval_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      aggregate_mode <= wmmas_pkg::MODE_ALL;
      interval_ticks <= '0;
    end else if (reg_write) begin
      case (reg_index)
        wmmas_pkg::REG_ENABLE:   enable         <= pwdata[0];
        wmmas_pkg::REG_MODE:     aggregate_mode <= pwdata[1:0];
        wmmas_pkg::REG_INTERVAL: interval_ticks <= pwdata[TW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      wmmas_pkg::REG_ENABLE:   prdata = {{(wmmas_pkg::PDATA_WIDTH-1){1'b0}}, enable};
      wmmas_pkg::REG_MODE:     prdata = {{(wmmas_pkg::PDATA_WIDTH-2){1'b0}}, aggregate_mode};
      wmmas_pkg::REG_INTERVAL: prdata = {1'b0, interval_ticks};
      default:                 prdata = '0;
    endcase
  end

  wmmas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .st        (st),
    .cmd       (cmd),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

  wmmas_dp #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .st           (st),
    .in_command   (in_ch.command),
    .in_operand   (in_ch.operand),
    .in_timestamp (in_ch.timestamp),
    .out_kind     (out_ch.kind),
    .out_value    (out_ch.result_value),
    .out_last     (out_ch.last)
  );

endmodule

@@ design/wmmas_div.sv @@
// Restoring divider that averages a closed window: one quotient bit per cycle.
// Takes a signed sum and an unsigned count; the quotient truncates toward zero.
module wmmas_div #(
  parameter int VALUE_WIDTH = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] sum,
  input  logic [COUNT_WIDTH-1:0] count,
  output logic                   busy,
  output logic [VALUE_WIDTH-1:0] quotient
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] dvd;
  logic [COUNT_WIDTH-1:0] dvs;
  logic [COUNT_WIDTH-1:0] rem;
  logic                   neg;
  logic                   prep;
  logic [CNT_W-1:0]       cnt;
  logic [COUNT_WIDTH:0]   shifted;
  logic [COUNT_WIDTH:0]   diff;
  logic                   fits;

  assign shifted  = {rem, dvd[VALUE_WIDTH-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign diff     = shifted - {1'b0, dvs};
  assign busy     = prep || (cnt != '0);
  assign quotient = neg ? (~dvd + 1'b1) : dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      prep <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      dvd  <= sum;
      neg  <= sum[VALUE_WIDTH-1];
      dvs  <= count;
      rem  <= '0;
      prep <= 1'b1;
      cnt  <= CNT_W'(VALUE_WIDTH);
    end else if (prep) begin
      dvd  <= neg ? (~dvd + 1'b1) : dvd;
      prep <= 1'b0;
    end else if (cnt != '0) begin
      rem <= fits ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
      dvd <= {dvd[VALUE_WIDTH-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

@@ design/wmmas_dp.sv @@
// Datapath: current value, window state, deadline, snapshots and the result register.
// Depends on wmmas_pkg and instantiates wmmas_div for the window average.
module wmmas_dp #(
  parameter int VALUE_WIDTH = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  wmmas_pkg::cfg_t                        cfg,
  input  wmmas_pkg::cmd_t                        cmd,
  output wmmas_pkg::stat_t                       st,
  input  logic                                   in_command,
  input  logic signed [wmmas_pkg::PORT_WIDTH-1:0] in_operand,
  input  logic [wmmas_pkg::TS_WIDTH-1:0]         in_timestamp,
  output logic [1:0]                             out_kind,
  output logic signed [wmmas_pkg::PORT_WIDTH-1:0] out_value,
  output logic                                   out_last
);

  localparam int TW = wmmas_pkg::TS_WIDTH;
  localparam logic [VALUE_WIDTH-1:0] MIN_INIT = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] MAX_INIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [VALUE_WIDTH-1:0] current_value;
  logic [VALUE_WIDTH-1:0] window_min;
  logic [VALUE_WIDTH-1:0] window_max;
  logic [VALUE_WIDTH-1:0] window_sum;
  logic [COUNT_WIDTH-1:0] sample_count;
  logic [TW-1:0]          deadline;
  logic [TW-1:0]          ts_q;
  logic [VALUE_WIDTH-1:0] snap_min;
  logic [VALUE_WIDTH-1:0] snap_max;

  logic [VALUE_WIDTH-1:0] opnd_v;
  logic [VALUE_WIDTH-1:0] value_next;
  logic [VALUE_WIDTH-1:0] min_next;
  logic [VALUE_WIDTH-1:0] max_next;
  logic [VALUE_WIDTH-1:0] sum_next;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [TW:0]            ts_sum;
  logic [TW-1:0]          deadline_next;
  logic                   div_start;
  logic                   div_busy;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic signed [VALUE_WIDTH-1:0] sel_value;

  assign opnd_v     = in_operand[VALUE_WIDTH-1:0];
  assign value_next = in_command ? (current_value + opnd_v) : opnd_v;

  assign count_next = (sample_count == '1) ? sample_count : (sample_count + 1'b1);
  assign min_next   = ($signed(current_value) < $signed(window_min)) ? current_value
                                                                     : window_min;
  assign max_next   = ($signed(window_max) < $signed(current_value)) ? current_value
                                                                     : window_max;
  assign sum_next   = window_sum + current_value;

  assign ts_sum        = {1'b0, ts_q} + {1'b0, cfg.interval};
  assign deadline_next = ts_sum[TW] ? {TW{1'b1}} : ts_sum[TW-1:0];

  assign div_start    = cmd.update_window && cmd.close_window;
  assign st.close_now = cfg.enable && (in_timestamp > deadline);
  assign st.avg_ready = !div_busy;

  wmmas_div #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .sum      (sum_next),
    .count    (count_next),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  always_comb begin
    case (cmd.out_kind)
      wmmas_pkg::KIND_CUR: sel_value = value_next;
      wmmas_pkg::KIND_MIN: sel_value = snap_min;
      wmmas_pkg::KIND_MAX: sel_value = snap_max;
      wmmas_pkg::KIND_AVG: sel_value = div_quot;
      default:             sel_value = value_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_value <= '0;
      window_min    <= MIN_INIT;
      window_max    <= MAX_INIT;
      window_sum    <= '0;
      sample_count  <= '0;
      deadline      <= '0;
    end else begin
      if (cmd.take_item) begin
        current_value <= value_next;
      end
      if (cmd.update_window) begin
        if (cmd.close_window) begin
          window_min   <= MIN_INIT;
          window_max   <= MAX_INIT;
          window_sum   <= '0;
          sample_count <= '0;
          deadline     <= deadline_next;
        end else begin
          window_min   <= min_next;
          window_max   <= max_next;
          window_sum   <= sum_next;
          sample_count <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      ts_q <= in_timestamp;
    end
    if (div_start) begin
      snap_min <= min_next;
      snap_max <= max_next;
    end
    if (cmd.load_out) begin
      out_kind  <= cmd.out_kind;
      out_value <= wmmas_pkg::PORT_WIDTH'(sel_value);
      out_last  <= cmd.out_last;
    end
  end

endmodule

@@ design/wmmas_ctrl.sv @@
// Controller state machine: sequences item intake, window update and result emission.
// Depends on wmmas_pkg; drives the datapath through command and status structs.
module wmmas_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  wmmas_pkg::cfg_t  cfg,
  input  wmmas_pkg::stat_t st,
  output wmmas_pkg::cmd_t  cmd,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_MIN,
    S_MAX,
    S_AVG
  } state_t;

  state_t state;
  state_t state_next;
  logic   closing;
  logic   closing_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.out_kind = wmmas_pkg::KIND_CUR;
    in_ready     = 1'b0;
    state_next   = state;
    closing_next = closing;
    case (state)
      S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          cmd.take_item = 1'b1;
          cmd.load_out  = 1'b1;
          cmd.out_kind  = wmmas_pkg::KIND_CUR;
          cmd.out_last  = !st.close_now;
          closing_next  = st.close_now;
          state_next    = cfg.enable ? S_UPD : S_IDLE;
        end
      end
      S_UPD: begin
        cmd.update_window = 1'b1;
        cmd.close_window  = closing;
        if (!closing) begin
          state_next = S_IDLE;
        end else if (cfg.mode == wmmas_pkg::MODE_MAX) begin
          state_next = S_MAX;
        end else if (cfg.mode == wmmas_pkg::MODE_AVG) begin
          state_next = S_AVG;
        end else begin
          state_next = S_MIN;
        end
      end
      S_MIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = wmmas_pkg::KIND_MIN;
          cmd.out_last = (cfg.mode == wmmas_pkg::MODE_MIN);
          state_next   = (cfg.mode == wmmas_pkg::MODE_ALL) ? S_MAX : S_IDLE;
        end
      end
      S_MAX: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = wmmas_pkg::KIND_MAX;
          cmd.out_last = (cfg.mode == wmmas_pkg::MODE_MAX);
          state_next   = (cfg.mode == wmmas_pkg::MODE_ALL) ? S_AVG : S_IDLE;
        end
      end
      S_AVG: begin
        if (out_free && st.avg_ready) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = wmmas_pkg::KIND_AVG;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      closing   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      closing <= closing_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench for windowed_min_max_avg_stats_top: directed and random traffic under random
// backpressure (none in quiet phases), checked against an in-bench statistics model.
// Depends on wmmas_pkg, the channel interfaces and the top level of the block.
module tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_ITEMS = 60;
  localparam logic [62:0] TS_MAX = '1;
  localparam logic signed [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    wmmas_pkg::kind_t   kind;
    logic signed [63:0] value;
    logic               last;
  } result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [wmmas_pkg::PADDR_WIDTH-1:0] paddr;
  logic [wmmas_pkg::PDATA_WIDTH-1:0] pwdata;
  logic [wmmas_pkg::PDATA_WIDTH-1:0] prdata;
  logic pready;

  wmmas_in_if  in_ch();
  wmmas_out_if out_ch();

  windowed_min_max_avg_stats_top dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  logic               cfg_enable;
  logic [1:0]         cfg_mode;
  logic [62:0]        cfg_interval;
  logic signed [63:0] cur_value;
  logic signed [63:0] win_min;
  logic signed [63:0] win_max;
  logic signed [63:0] win_sum;
  logic [31:0]        win_count;
  logic [62:0]        deadline_ts;
  logic [62:0]        tnow;

  result_t expected_results[$];

  int  cycles = 0;
  int  errors = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  windows_closed = 0;
  int  stall_left = 0;
  bit  quiet = 0;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic restart_window();
    win_min = VAL_MAX;
    win_max = VAL_MIN;
    win_sum = '0;
    win_count = '0;
  endtask

  task automatic update_stats(input logic cmd, input logic signed [63:0] op,
                              input logic [62:0] ts);
    logic signed [63:0] nv;
    logic signed [63:0] mean;
    logic [63:0] mag;
    logic [63:0] quot;
    logic [63:0] next_deadline;
    logic closing;
    nv = cmd ? cur_value + op : op;
    cur_value = nv;
    closing = cfg_enable && (ts > deadline_ts);
    expected_results.push_back('{wmmas_pkg::KIND_CUR, nv, !closing});
    if (cfg_enable) begin
      if (win_count != '1) win_count = win_count + 1'b1;
      if (nv < win_min) win_min = nv;
      if (nv > win_max) win_max = nv;
      win_sum = win_sum + nv;
    end
    if (closing) begin
      mag = win_sum[63] ? -win_sum : win_sum;
      quot = mag / {32'd0, win_count};
      mean = win_sum[63] ? -quot : quot;
      next_deadline = {1'b0, ts} + {1'b0, cfg_interval};
      deadline_ts = next_deadline[63] ? TS_MAX : next_deadline[62:0];
      case (cfg_mode)
        wmmas_pkg::MODE_ALL: begin
          expected_results.push_back('{wmmas_pkg::KIND_MIN, win_min, 1'b0});
          expected_results.push_back('{wmmas_pkg::KIND_MAX, win_max, 1'b0});
          expected_results.push_back('{wmmas_pkg::KIND_AVG, mean, 1'b1});
        end
        wmmas_pkg::MODE_MIN: expected_results.push_back('{wmmas_pkg::KIND_MIN, win_min, 1'b1});
        wmmas_pkg::MODE_MAX: expected_results.push_back('{wmmas_pkg::KIND_MAX, win_max, 1'b1});
        default: expected_results.push_back('{wmmas_pkg::KIND_AVG, mean, 1'b1});
      endcase
      restart_window();
      windows_closed++;
    end
  endtask

  task automatic send_item(input logic cmd, input logic signed [63:0] op,
                           input logic [62:0] ts);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.operand <= op;
    in_ch.timestamp <= ts;
    do @(posedge clk); while (!in_ch.ready);
    update_stats(cmd, op, ts);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      wmmas_pkg::REG_ENABLE: cfg_enable = data[0];
      wmmas_pkg::REG_MODE: cfg_mode = data[1:0];
      default: cfg_interval = data[62:0];
    endcase
  endtask

  task automatic configure(input logic en, input logic [1:0] mode,
                           input logic [62:0] interval);
    drain_results();
    write_reg(wmmas_pkg::REG_ENABLE, 64'(en));
    write_reg(wmmas_pkg::REG_MODE, 64'(mode));
    write_reg(wmmas_pkg::REG_INTERVAL, 64'(interval));
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got = '{wmmas_pkg::kind_t'(out_ch.kind), out_ch.result_value, out_ch.last};
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= 20)
        $display("%t: unexpected result: kind %0d value %0d last %0b",
                 $time, got.kind, got.value, got.last);
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (got !== want) begin
        errors++;
        if (errors <= 20)
          $display("%t: expected kind %0d value %0d last %0b, got kind %0d value %0d last %0b",
                   $time, want.kind, want.value, want.last, got.kind, got.value, got.last);
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("windowed_min_max_avg_stats_top: mismatch");
      $finish;
    end else if (!rst && out_ch.valid && out_ch.ready) begin
      check_result();
    end
  end

  task automatic test_disabled_tracking();
    configure(1'b0, wmmas_pkg::MODE_ALL, '0);
    send_item(1'b0, VAL_MAX, '0);
    send_item(1'b1, 64'sd1, TS_MAX);
    send_item(1'b0, VAL_MIN, TS_MAX);
    send_item(1'b1, -64'sd1, 63'd7);
    send_item(1'b1, '1, '0);
    send_item(1'b0, '0, '0);
  endtask

  task automatic test_window_close_all();
    configure(1'b1, wmmas_pkg::MODE_ALL, '0);
    send_item(1'b0, -64'sd7, '0);
    send_item(1'b0, 64'sd0, '0);
    send_item(1'b1, 64'sd0, 63'd1);
    send_item(1'b0, VAL_MAX, 63'd1);
    send_item(1'b0, VAL_MAX, 63'd1);
    send_item(1'b1, 64'sd0, 63'd2);
    send_item(1'b0, VAL_MIN, 63'd2);
    send_item(1'b1, -64'sd1, 63'd3);
    send_item(1'b0, 64'sd5, 63'd10);
    tnow = 63'd10;
  endtask

  task automatic test_single_aggregates();
    for (int m = wmmas_pkg::MODE_MIN; m <= wmmas_pkg::MODE_AVG; m++) begin
      configure(1'b1, 2'(m), 63'd3);
      send_item(1'b0, -64'sd20, tnow);
      send_item(1'b1, 64'sd9, tnow + 63'd2);
      send_item(1'b1, 64'sd4, tnow + 63'd4);
      tnow = tnow + 63'd4;
    end
  endtask

  task automatic test_random_traffic();
    int pick;
    logic signed [63:0] op;
    logic [62:0] ts;
    logic [62:0] interval;
    for (int ph = 0; ph < 6; ph++) begin
      quiet = (ph == 3 || ph == 5);
      interval = (ph == 0) ? 63'd0 :
                 (ph == 4) ? 63'($urandom_range(20, 200)) : 63'($urandom_range(1, 8));
      configure(ph != 1, (ph == 0) ? wmmas_pkg::MODE_ALL : 2'($urandom_range(0, 3)),
                interval);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 7);
        case (pick)
          0: begin
            case ($urandom_range(0, 3))
              0: op = VAL_MAX;
              1: op = VAL_MIN;
              2: op = '0;
              default: op = '1;
            endcase
          end
          1, 2: begin
            op = 64'($urandom_range(0, 200));
            op = op - 64'sd100;
          end
          default: op = {$urandom, $urandom};
        endcase
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          tnow = tnow + 63'({16'($urandom_range(0, 65535)), 32'($urandom)});
          ts = tnow;
        end else if (pick == 1) begin
          ts = 63'($urandom);
        end else begin
          tnow = tnow + 63'($urandom_range(0, 4));
          ts = tnow;
        end
        send_item(1'($urandom_range(0, 1)), op, ts);
      end
    end
  endtask

  task automatic test_deadline_saturation();
    configure(1'b1, wmmas_pkg::MODE_ALL, TS_MAX);
    send_item(1'b0, 64'sd3, TS_MAX - 63'd3);
    send_item(1'b1, 64'sd1, TS_MAX);
    send_item(1'b1, 64'sd1, '0);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = 1'b0;
    in_ch.operand = '0;
    in_ch.timestamp = '0;
    out_ch.ready = 1'b0;
    cfg_enable = 1'b0;
    cfg_mode = wmmas_pkg::MODE_ALL;
    cfg_interval = '0;
    cur_value = '0;
    deadline_ts = '0;
    tnow = '0;
    restart_window();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_disabled_tracking();
    test_window_close_all();
    test_single_aggregates();
    test_random_traffic();
    test_deadline_saturation();
    drain_results();

    $display("Sent %0d items and checked %0d results over %0d window closes,", items_sent,
             results_checked, windows_closed);
    $display("covering set and add, all aggregate modes, disabled tracking and deadline limits.");
    if (errors == 0) begin
      $display("windowed_min_max_avg_stats_top: match");
    end else begin
      $display("windowed_min_max_avg_stats_top: mismatch");
    end
    $finish;
  end

endmodule
